[sv/venk_lim_pkg.sv]
// Package with the types, constants and fixed-point helpers of the slope limiter.
`timescale 1ns / 1ps
`default_nettype none
package venk_lim_pkg;

  localparam int MAX_FACES = 4;
  localparam int FRAC_BITS = 16;
  localparam int IW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CW  = $clog2(MAX_FACES + 1);
  localparam int DCW = $clog2(FRAC_BITS + 1);
  localparam int LIM_W = FRAC_BITS + 1;
  localparam int SUM_W = 67;
  localparam logic [LIM_W-1:0] LIM_ONE = LIM_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] center_value;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] neighbour_value;
    logic signed [31:0] face_dx;
    logic signed [31:0] face_dy;
    logic signed [31:0] recon_dx;
    logic signed [31:0] recon_dy;
    logic               last_face;
  } in_item_t;

  typedef struct packed {
    logic [16:0]        limiter;
    logic signed [31:0] face_value;
    logic               too_many_faces;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PMUL0, ST_PMUL1, ST_PACC,
    ST_LSEL, ST_LM0, ST_LM1, ST_LM2, ST_LSUM, ST_LCMP, ST_LDIV,
    ST_RMUL0, ST_RMUL1, ST_RACC, ST_FMUL, ST_FACC, ST_OUT
  } state_e;

  // Division by 2^FRAC_BITS, truncating toward zero.
  function automatic logic signed [SUM_W-1:0] trunc_frac(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s;
    if (s < 0) begin
      t = s + ((SUM_W'(1) <<< FRAC_BITS) - SUM_W'(1));
    end
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] s);
    logic signed [31:0] r;
    r = s[31:0];
    if (s > SUM_W'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (s < -SUM_W'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/venkatakrishnan_limited_face_value.sv]
// Top level of the Venkatakrishnan slope limiter with limited face reconstruction.
//
//  Channel | Direction | Handshake                      | Payload
//  in      | request   | in_valid_i / in_ready_o        | in_item_i  (venk_lim_pkg::in_item_t)
//  out     | result    | out_valid_o / out_ready_i      | out_item_o (venk_lim_pkg::out_item_t)
//  cfg     | request   | cfg_valid_i / cfg_ready_o      | cfg_data_i (smoothing term)
//
// A request that is not the last face of its cell passes PMUL0, PMUL1 and PACC: one shared
// 33 by 33 bit multiplier forms the two products of the face projection in turn.
// The last face adds, for every stored face with a non-zero projection, the states LSEL, LM0,
// LM1, LM2, LSUM and LCMP for selection, products, sums and comparison, plus restoring division
// in LDIV, one quotient bit per cycle, when that face's ratio is below one; a face with a zero
// projection only passes LSEL. A final LSEL ends the scan, and RMUL0, RMUL1, RACC, FMUL, FACC
// and OUT form the face value and publish it.
// Reset clears the sequencer, the face count and the running extrema; the projection
// store needs no reset because only entries written in the current cell are read.
// A finished result waits in the output register while the next request is taken; the
// sequencer stalls at the end of a cell only if the previous result is still unclaimed.
`timescale 1ns / 1ps
`default_nettype none
module venkatakrishnan_limited_face_value (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire venk_lim_pkg::in_item_t in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output venk_lim_pkg::out_item_t  out_item_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire [30:0]               cfg_data_i
);

  localparam int SW = venk_lim_pkg::SUM_W;
  localparam int FB = venk_lim_pkg::FRAC_BITS;

  venk_lim_pkg::state_e state_q, state_d;

  venk_lim_pkg::in_item_t item_q;
  venk_lim_pkg::out_item_t out_q;
  logic                    out_valid_q;
  logic [30:0]             smooth_q;

  logic signed [31:0] proj_q [venk_lim_pkg::MAX_FACES];
  logic signed [31:0] max_q, min_q;
  logic [venk_lim_pkg::CW-1:0] cnt_q, idx_q;
  logic                         ovf_seen_q, ovf_item_q;

  // Shared multiplier and its registered product.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [65:0] acc_q;

  // Limiter working registers.
  logic [31:0]                  ua_q, ub_q;
  logic [SW-1:0]                num_q, den_q, rem_q;
  logic [FB-1:0]                quo_q;
  logic [venk_lim_pkg::DCW-1:0] dcnt_q;
  logic [venk_lim_pkg::LIM_W-1:0] lim_q;
  logic signed [31:0]           dot_q;
  logic signed [31:0]           fv_q;

  logic signed [31:0] sel_proj;
  logic signed [SW-1:0] dot_sum;
  logic [SW:0]          rem_shift;
  logic [SW-1:0]        kt;
  logic                 in_acc;

  assign sel_proj    = proj_q[idx_q[venk_lim_pkg::IW-1:0]];
  assign dot_sum     = SW'(acc_q) + SW'(prod_q);
  assign rem_shift   = {rem_q, 1'b0};
  assign kt          = SW'({smooth_q, FB'(0)});
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      venk_lim_pkg::ST_IDLE:  if (in_valid_i) state_d = venk_lim_pkg::ST_PMUL0;
      venk_lim_pkg::ST_PMUL0: state_d = venk_lim_pkg::ST_PMUL1;
      venk_lim_pkg::ST_PMUL1: state_d = venk_lim_pkg::ST_PACC;
      venk_lim_pkg::ST_PACC: begin
        state_d = item_q.last_face ? venk_lim_pkg::ST_LSEL : venk_lim_pkg::ST_IDLE;
      end
      venk_lim_pkg::ST_LSEL: begin
        if (idx_q == cnt_q) begin
          state_d = venk_lim_pkg::ST_RMUL0;
        end else if (sel_proj != 0) begin
          state_d = venk_lim_pkg::ST_LM0;
        end
      end
      venk_lim_pkg::ST_LM0:  state_d = venk_lim_pkg::ST_LM1;
      venk_lim_pkg::ST_LM1:  state_d = venk_lim_pkg::ST_LM2;
      venk_lim_pkg::ST_LM2:  state_d = venk_lim_pkg::ST_LSUM;
      venk_lim_pkg::ST_LSUM: state_d = venk_lim_pkg::ST_LCMP;
      venk_lim_pkg::ST_LCMP: begin
        state_d = (num_q >= den_q) ? venk_lim_pkg::ST_LSEL : venk_lim_pkg::ST_LDIV;
      end
      venk_lim_pkg::ST_LDIV: begin
        if (dcnt_q == venk_lim_pkg::DCW'(FB - 1)) state_d = venk_lim_pkg::ST_LSEL;
      end
      venk_lim_pkg::ST_RMUL0: state_d = venk_lim_pkg::ST_RMUL1;
      venk_lim_pkg::ST_RMUL1: state_d = venk_lim_pkg::ST_RACC;
      venk_lim_pkg::ST_RACC:  state_d = venk_lim_pkg::ST_FMUL;
      venk_lim_pkg::ST_FMUL:  state_d = venk_lim_pkg::ST_FACC;
      venk_lim_pkg::ST_FACC:  state_d = venk_lim_pkg::ST_OUT;
      venk_lim_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = venk_lim_pkg::ST_IDLE;
      end
      default: state_d = venk_lim_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier operand selection.
  always_comb begin
    in_ready_o = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      venk_lim_pkg::ST_IDLE: in_ready_o = 1'b1;
      venk_lim_pkg::ST_PMUL0: begin
        mul_a = 33'(item_q.face_dx);
        mul_b = 33'(item_q.grad_x);
      end
      venk_lim_pkg::ST_PMUL1: begin
        mul_a = 33'(item_q.face_dy);
        mul_b = 33'(item_q.grad_y);
      end
      venk_lim_pkg::ST_LM0: begin
        mul_a = {1'b0, ua_q};
        mul_b = {1'b0, ua_q};
      end
      venk_lim_pkg::ST_LM1: begin
        mul_a = {1'b0, ua_q};
        mul_b = {1'b0, ub_q};
      end
      venk_lim_pkg::ST_LM2: begin
        mul_a = {1'b0, ub_q};
        mul_b = {1'b0, ub_q};
      end
      venk_lim_pkg::ST_RMUL0: begin
        mul_a = 33'(item_q.recon_dx);
        mul_b = 33'(item_q.grad_x);
      end
      venk_lim_pkg::ST_RMUL1: begin
        mul_a = 33'(item_q.recon_dy);
        mul_b = 33'(item_q.grad_y);
      end
      venk_lim_pkg::ST_FMUL: begin
        mul_a = 33'({16'b0, lim_q});
        mul_b = 33'(dot_q);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= venk_lim_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      smooth_q    <= '0;
      cnt_q       <= '0;
      ovf_seen_q  <= 1'b0;
      max_q       <= '0;
      min_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        smooth_q <= cfg_data_i;
      end
      if (in_acc) begin
        if (cnt_q >= venk_lim_pkg::CW'(venk_lim_pkg::MAX_FACES)) begin
          ovf_seen_q <= 1'b1;
        end else if (cnt_q == '0) begin
          // The first face of a cell seeds the extrema from the cell value and its neighbour value.
          max_q <= (in_item_i.neighbour_value > in_item_i.center_value) ?
                   in_item_i.neighbour_value : in_item_i.center_value;
          min_q <= (in_item_i.neighbour_value < in_item_i.center_value) ?
                   in_item_i.neighbour_value : in_item_i.center_value;
        end else begin
          if (in_item_i.center_value > max_q && in_item_i.center_value >=
              in_item_i.neighbour_value) begin
            max_q <= in_item_i.center_value;
          end else if (in_item_i.neighbour_value > max_q) begin
            max_q <= in_item_i.neighbour_value;
          end
          if (in_item_i.center_value < min_q && in_item_i.center_value <=
              in_item_i.neighbour_value) begin
            min_q <= in_item_i.center_value;
          end else if (in_item_i.neighbour_value < min_q) begin
            min_q <= in_item_i.neighbour_value;
          end
        end
      end
      if (state_q == venk_lim_pkg::ST_PACC && !ovf_item_q) begin
        cnt_q <= cnt_q + venk_lim_pkg::CW'(1);
      end
      if (state_q == venk_lim_pkg::ST_OUT && (!out_valid_q || out_ready_i)) begin
        // The cell is finished: publish the result and clear the per-cell state.
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        ovf_seen_q  <= 1'b0;
        max_q       <= '0;
        min_q       <= '0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      item_q     <= in_item_i;
      ovf_item_q <= (cnt_q >= venk_lim_pkg::CW'(venk_lim_pkg::MAX_FACES));
    end
    case (state_q)
      venk_lim_pkg::ST_PMUL1, venk_lim_pkg::ST_RMUL1: acc_q <= prod_q;
      venk_lim_pkg::ST_PACC: begin
        if (!ovf_item_q) begin
          proj_q[cnt_q[venk_lim_pkg::IW-1:0]] <=
            venk_lim_pkg::sat32(venk_lim_pkg::trunc_frac(dot_sum));
        end
        idx_q <= '0;
        lim_q <= venk_lim_pkg::LIM_ONE;
      end
      venk_lim_pkg::ST_LSEL: begin
        if (idx_q != cnt_q) begin
          if (sel_proj == 0) begin
            idx_q <= idx_q + venk_lim_pkg::CW'(1);
          end else begin
            // Distance to the relevant extremum, clamped at zero when it has the wrong sign.
            logic signed [32:0] a;
            if (sel_proj > 0) begin
              a    = 33'(max_q) - 33'(item_q.center_value);
              ub_q <= 32'(sel_proj);
            end else begin
              a    = 33'(item_q.center_value) - 33'(min_q);
              ub_q <= 32'(-33'(sel_proj));
            end
            ua_q <= (a > 0) ? a[31:0] : '0;
          end
        end
      end
      venk_lim_pkg::ST_LM1: begin
        num_q <= SW'(prod_q) + kt;
        den_q <= SW'(prod_q) + kt;
      end
      venk_lim_pkg::ST_LM2: begin
        num_q <= num_q + (SW'(prod_q) << 1);
        den_q <= den_q + SW'(prod_q);
      end
      venk_lim_pkg::ST_LSUM: den_q <= den_q + (SW'(prod_q) << 1);
      venk_lim_pkg::ST_LCMP: begin
        rem_q  <= num_q;
        quo_q  <= '0;
        dcnt_q <= '0;
        if (num_q >= den_q) begin
          idx_q <= idx_q + venk_lim_pkg::CW'(1);
        end
      end
      venk_lim_pkg::ST_LDIV: begin
        logic [FB-1:0] nq;
        if (rem_shift >= {1'b0, den_q}) begin
          rem_q <= SW'(rem_shift - {1'b0, den_q});
          nq    = {quo_q[FB-2:0], 1'b1};
        end else begin
          rem_q <= SW'(rem_shift);
          nq    = {quo_q[FB-2:0], 1'b0};
        end
        quo_q  <= nq;
        dcnt_q <= dcnt_q + venk_lim_pkg::DCW'(1);
        if (dcnt_q == venk_lim_pkg::DCW'(FB - 1)) begin
          idx_q <= idx_q + venk_lim_pkg::CW'(1);
          if ({1'b0, nq} < lim_q) lim_q <= {1'b0, nq};
        end
      end
      venk_lim_pkg::ST_RACC: dot_q <= venk_lim_pkg::sat32(venk_lim_pkg::trunc_frac(dot_sum));
      venk_lim_pkg::ST_FACC: begin
        fv_q <= venk_lim_pkg::sat32(venk_lim_pkg::trunc_frac(SW'(prod_q)) +
                                    SW'(item_q.center_value));
      end
      venk_lim_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.limiter        <= lim_q;
          out_q.face_value     <= fv_q;
          out_q.too_many_faces <= ovf_seen_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[sv/venk_lim_checker.sv]
// Port-level checker for the slope limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module venk_lim_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_ready_o,
  input wire                     out_valid_o,
  input wire                     out_ready_i,
  input wire venk_lim_pkg::out_item_t out_item_o
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // The limiter never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.limiter <= 17'h10000)
    else $error("limiter above one");

  // After an accepted request the sequencer is busy and takes no new request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the sequencer was busy");

  // A new result is only published from the end of a busy sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a finished cell");

endmodule

bind venkatakrishnan_limited_face_value venk_lim_checker u_venk_lim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
